FILE: hdl/fat16_cluster_chain_reader_top_assert.svh
// Assertion macros shared by the reader modules.
// Both expect clk and rst_n in scope.
`ifndef FAT16_CLUSTER_CHAIN_READER_TOP_ASSERT_SVH
`define FAT16_CLUSTER_CHAIN_READER_TOP_ASSERT_SVH

// same-cycle implication
`define FCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FAT    = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic [1:0] CFG_DATA_BASE     = 2'd0;
    localparam logic [1:0] CFG_FAT_BASE      = 2'd1;
    localparam logic [1:0] CFG_CLUSTER_BYTES = 2'd2;

    localparam logic [16:0] CLUSTER_BYTES_RST = 17'd512;
    localparam logic [16:0] FAT_ENTRY_BYTES   = 17'd2;

    // queue depth, power of two
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef struct packed {
        logic        has_data;
        logic [1:0]  tail_kind;
        logic [15:0] cluster;
        logic [16:0] offset;
        logic [16:0] len;
        logic [31:0] total;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

FILE: hdl/fcr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [47:0]     s_tdata,   // cluster_value[15:0], byte_count[47:16]
    input  wire logic [1:0]      s_tuser,   // opcode[1:0]
    input  wire logic [16:0]     cluster_bytes,
    input  wire fcr_pkg::q_stat_t q_stat,
    output logic                 push,
    output fcr_pkg::job_t        push_job
);

`include "fat16_cluster_chain_reader_top_assert.svh"

    logic [15:0] cluster_reg, cluster_next;
    logic [16:0] offset_reg, offset_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] req_left_reg, req_left_next;
    logic [31:0] req_total_reg, req_total_next;
    logic        await_reg, await_next;

    logic        acc;
    logic [1:0]  op;
    logic [15:0] cv;
    logic [31:0] cnt;

    logic [15:0] ch_cluster;
    logic [31:0] ch_req;
    logic [31:0] ch_tot;
    logic [16:0] ch_room;
    logic [16:0] ch_len;
    logic [31:0] ch_rem;
    logic [17:0] ch_off_sum;
    logic [16:0] ch_off;
    logic        ch_wrap;
    logic        ch_fat;
    logic [31:0] ch_req_n;
    logic [31:0] ch_tot_n;

    logic        fat_push;

    assign s_tready = !q_stat.full;
    assign acc      = s_tvalid && s_tready;
    assign op       = s_tuser;
    assign cv       = s_tdata[15:0];
    assign cnt      = s_tdata[47:16];
    assign fat_push = push && (push_job.tail_kind == fcr_pkg::KIND_FAT);

    // one data chunk from the current position
    always_comb
    begin
        if (op == fcr_pkg::OP_REPLY)
        begin
            ch_cluster = cv;
            ch_req     = req_left_reg;
            ch_tot     = req_total_reg;
        end
        else
        begin
            ch_cluster = cluster_reg;
            ch_req     = cnt;
            ch_tot     = 32'd0;
        end
        ch_room = (offset_reg < cluster_bytes) ? (cluster_bytes - offset_reg) : 17'd0;
        ch_len  = ch_room;
        if (ch_req < {15'd0, ch_len})
            ch_len = ch_req[16:0];
        if (rem_reg < {15'd0, ch_len})
            ch_len = rem_reg[16:0];
        ch_rem     = rem_reg - {15'd0, ch_len};
        ch_off_sum = {1'b0, offset_reg} + {1'b0, ch_len};
        ch_off     = ch_off_sum[16:0];
        ch_wrap    = ch_off >= cluster_bytes;
        ch_fat     = ch_wrap && (ch_rem != 32'd0);
        ch_req_n   = ch_req - {15'd0, ch_len};
        ch_tot_n   = ch_tot + {15'd0, ch_len};
    end

    always_comb
    begin
        cluster_next   = cluster_reg;
        offset_next    = offset_reg;
        rem_next       = rem_reg;
        req_left_next  = req_left_reg;
        req_total_next = req_total_reg;
        await_next     = await_reg;
        push           = 1'b0;
        push_job       = '0;
        if (acc)
        begin
            case (op)
                fcr_pkg::OP_OPEN:
                begin
                    cluster_next   = cv;
                    offset_next    = 17'd0;
                    rem_next       = cnt;
                    req_left_next  = 32'd0;
                    req_total_next = 32'd0;
                    await_next     = 1'b0;
                end
                fcr_pkg::OP_READ,
                fcr_pkg::OP_REPLY:
                begin
                    push = 1'b1;
                    if (await_reg != (op == fcr_pkg::OP_REPLY))
                    begin
                        push_job.tail_kind = fcr_pkg::KIND_REJECT;
                    end
                    else if ((op == fcr_pkg::OP_READ) &&
                             (rem_reg == 32'd0 || cluster_reg == 16'd0 || cnt == 32'd0))
                    begin
                        req_left_next      = 32'd0;
                        req_total_next     = 32'd0;
                        push_job.tail_kind = fcr_pkg::KIND_DONE;
                    end
                    else if ((op == fcr_pkg::OP_REPLY) &&
                             (req_left_reg == 32'd0 || rem_reg == 32'd0))
                    begin
                        cluster_next       = cv;
                        await_next         = 1'b0;
                        push_job.tail_kind = fcr_pkg::KIND_DONE;
                        push_job.total     = req_total_reg;
                    end
                    else
                    begin
                        cluster_next      = ch_cluster;
                        rem_next          = ch_rem;
                        offset_next       = ch_wrap ? 17'd0 : ch_off;
                        req_left_next     = ch_req_n;
                        req_total_next    = ch_tot_n;
                        await_next        = ch_fat;
                        push_job.has_data = 1'b1;
                        push_job.cluster  = ch_cluster;
                        push_job.offset   = offset_reg;
                        push_job.len      = ch_len;
                        if (ch_fat)
                        begin
                            push_job.tail_kind = fcr_pkg::KIND_FAT;
                        end
                        else
                        begin
                            push_job.tail_kind = fcr_pkg::KIND_DONE;
                            push_job.total     = ch_tot_n;
                        end
                    end
                end
                default:
                begin
                    push               = 1'b1;
                    push_job.tail_kind = fcr_pkg::KIND_REJECT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_reg   <= 16'd0;
            offset_reg    <= 17'd0;
            rem_reg       <= 32'd0;
            req_left_reg  <= 32'd0;
            req_total_reg <= 32'd0;
            await_reg     <= 1'b0;
        end
        else
        begin
            cluster_reg   <= cluster_next;
            offset_reg    <= offset_next;
            rem_reg       <= rem_next;
            req_left_reg  <= req_left_next;
            req_total_reg <= req_total_next;
            await_reg     <= await_next;
        end
    end

    `FCR_ASSERT_NEXT(a_fat_sets_wait, fat_push, await_reg, "FAT read without wait")

endmodule

`default_nettype wire

FILE: hdl/fcr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire fcr_pkg::job_t    push_job,
    input  wire logic             pop,
    output fcr_pkg::job_t         head,
    output fcr_pkg::q_stat_t      q_stat
);

`include "fat16_cluster_chain_reader_top_assert.svh"

    fcr_pkg::job_t                  mem_reg [fcr_pkg::QDEPTH];
    logic [fcr_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [fcr_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [fcr_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.empty = cnt_reg == '0;
    assign q_stat.full  = cnt_reg == fcr_pkg::QCNT_W'(fcr_pkg::QDEPTH);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    `FCR_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "queue overflow")
    `FCR_ASSERT_NOW(a_no_underflow, pop, !q_stat.empty, "queue underflow")

endmodule

`default_nettype wire

FILE: hdl/fcr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_back
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fcr_pkg::job_t    head,
    input  wire fcr_pkg::q_stat_t q_stat,
    output logic                  pop,
    input  wire logic [31:0]      data_base,
    input  wire logic [31:0]      fat_base,
    input  wire logic [16:0]      cluster_bytes,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [87:0]           m_tdata,  // command_address[31:0], transfer_length[48:32],
                                            // total_read[80:49], zero fill
    output logic [1:0]            m_tuser,  // command_kind[1:0]
    output logic                  m_tlast
);

`include "fat16_cluster_chain_reader_top_assert.svh"

    localparam logic PH_DATA = 1'b0;
    localparam logic PH_TAIL = 1'b1;

    fcr_pkg::job_t job_reg;
    logic          hold_reg;
    logic          phase_reg;
    logic [31:0]   prod_reg;
    logic [31:0]   prod_next;

    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [31:0]   out_addr_reg;
    logic [16:0]   out_len_reg;
    logic [31:0]   out_total_reg;
    logic          out_last_reg;

    logic          out_free;
    logic          emit;
    logic          tail_emit;
    logic          is_fat;
    logic          data_phase;

    assign out_free   = !out_valid_reg || m_tready;
    assign emit       = hold_reg && out_free;
    assign tail_emit  = emit && (phase_reg == PH_TAIL);
    assign pop        = !q_stat.empty && (!hold_reg || tail_emit);
    assign prod_next  = (32'(head.cluster) - 32'd2) * {15'd0, cluster_bytes};
    assign is_fat     = job_reg.tail_kind == fcr_pkg::KIND_FAT;
    assign data_phase = hold_reg && (phase_reg == PH_DATA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= 1'b0;
            phase_reg <= PH_DATA;
        end
        else if (pop)
        begin
            hold_reg  <= 1'b1;
            phase_reg <= head.has_data ? PH_DATA : PH_TAIL;
        end
        else if (tail_emit)
        begin
            hold_reg <= 1'b0;
        end
        else if (emit)
        begin
            phase_reg <= PH_TAIL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg  <= head;
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (phase_reg == PH_DATA)
            begin
                out_kind_reg  <= fcr_pkg::KIND_DATA;
                out_addr_reg  <= data_base + prod_reg + {15'd0, job_reg.offset};
                out_len_reg   <= job_reg.len;
                out_total_reg <= 32'd0;
                out_last_reg  <= 1'b0;
            end
            else
            begin
                out_kind_reg  <= job_reg.tail_kind;
                out_addr_reg  <= is_fat ? (fat_base + {15'd0, job_reg.cluster, 1'b0}) : 32'd0;
                out_len_reg   <= is_fat ? fcr_pkg::FAT_ENTRY_BYTES : 17'd0;
                out_total_reg <= job_reg.total;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_total_reg, out_len_reg, out_addr_reg};

    `FCR_ASSERT_NOW(a_data_phase_has_data, data_phase, job_reg.has_data, "job without data")

endmodule

`default_nettype wire

FILE: hdl/fat16_cluster_chain_reader_top.sv
// FAT16 cluster-chain reader.
// Input stream s_*: open (start cluster, file size), read (byte count) and
// FAT reply (next cluster) transactions, opcode on s_tuser.
// Output stream m_*: data read, FAT entry read, done and rejected commands,
// kind on m_tuser, m_tlast on the final command caused by one input.
// Config channel cfg_*: index 0 data_base, 1 fat_base, 2 cluster_bytes;
// always ready, write only while the block is idle.
// The first command of an item passes through the job queue, the job register
// and the output register of the command builder. The builder emits an item's
// commands in turn and pops the next item as it emits the last; opens yield none.
// A 4-entry job queue decouples the classifier from the command builder;
// s_tready drops only while that queue is full.
// A stalled m_tready holds the output register, fills the queue, then backs
// up to s_tready. Reset empties the queue and output, clears file state and
// loads cluster_bytes with 512, both base addresses with 0.
`timescale 1ns / 1ps
`default_nettype none

module fat16_cluster_chain_reader_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // cluster_value[15:0], byte_count[47:16]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // command_address[31:0], transfer_length[48:32],
                                        // total_read[80:49], zero fill
    output logic [1:0]       m_tuser,   // command_kind[1:0]
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0]      data_base_reg;
    logic [31:0]      fat_base_reg;
    logic [16:0]      cluster_bytes_reg;

    fcr_pkg::q_stat_t q_stat;
    fcr_pkg::job_t    push_job;
    fcr_pkg::job_t    head;
    logic             push;
    logic             pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_base_reg     <= 32'd0;
            fat_base_reg      <= 32'd0;
            cluster_bytes_reg <= fcr_pkg::CLUSTER_BYTES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fcr_pkg::CFG_DATA_BASE:     data_base_reg     <= cfg_data;
                fcr_pkg::CFG_FAT_BASE:      fat_base_reg      <= cfg_data;
                fcr_pkg::CFG_CLUSTER_BYTES: cluster_bytes_reg <= cfg_data[16:0];
                default:                    ;
            endcase
        end
    end

    fcr_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .cluster_bytes (cluster_bytes_reg),
        .q_stat        (q_stat),
        .push          (push),
        .push_job      (push_job)
    );

    fcr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    fcr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .data_base     (data_base_reg),
        .fat_base      (fat_base_reg),
        .cluster_bytes (cluster_bytes_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast)
    );

endmodule

`default_nettype wire
